// ===== design/vic_pkg.sv =====
// vic_pkg: shared constants, codes, types and a bit-scan helper for the vectored
// interrupt controller. No dependencies.
`default_nettype none

package vic_pkg;

   localparam int NUM_SOURCES   = 1024;
   localparam int NUM_OUT_LINES = 8;
   localparam int WORDS_MAX     = 32;
   localparam int NUM_WORDS     = (NUM_SOURCES + 31) / 32;
   localparam int GRP_DEPTH     = 4 * WORDS_MAX;
   localparam int GRP_AW        = $clog2(GRP_DEPTH);
   localparam int QUEUE_DEPTH   = 2;

   // command codes
   localparam logic [2:0] CMD_WRITE = 3'd0;
   localparam logic [2:0] CMD_READ  = 3'd1;
   localparam logic [2:0] CMD_LINE  = 3'd2;
   localparam logic [2:0] CMD_FAST  = 3'd3;
   localparam logic [2:0] CMD_RESET = 3'd4;

   // register block codes
   localparam logic [3:0] BLK_VID0    = 4'd0;
   localparam logic [3:0] BLK_VGRP    = 4'd1;
   localparam logic [3:0] BLK_ENABLE  = 4'd2;
   localparam logic [3:0] BLK_EN_CLR  = 4'd3;
   localparam logic [3:0] BLK_EN_SET  = 4'd4;
   localparam logic [3:0] BLK_TYPE    = 4'd5;
   localparam logic [3:0] BLK_STATUS  = 4'd6;
   localparam logic [3:0] BLK_CLEAR   = 4'd7;
   localparam logic [3:0] BLK_SOFT    = 4'd8;
   localparam logic [3:0] BLK_PENDING = 4'd9;
   localparam logic [3:0] BLK_GRP0    = 4'd10;
   localparam logic [3:0] BLK_GRP1    = 4'd11;
   localparam logic [3:0] BLK_GRP2    = 4'd12;
   localparam logic [3:0] BLK_GRP3    = 4'd13;

   // fast command codes
   localparam logic [1:0] FC_ENABLE  = 2'd0;
   localparam logic [1:0] FC_DISABLE = 2'd1;
   localparam logic [1:0] FC_SOFT    = 2'd2;
   localparam logic [1:0] FC_BAD     = 2'd3;

   typedef enum logic [4:0] {
      OP_NOP, OP_BAD, OP_VID0_WR, OP_EN_WR, OP_EN_CLR, OP_EN_SET,
      OP_TYPE_WR, OP_STAT_WR, OP_CLR_WR, OP_SOFT_WR, OP_PEND_WR,
      OP_GRP_WR, OP_RD_REG, OP_RD_GRP, OP_RD_ZERO, OP_LINE, OP_FAST,
      OP_RESET
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [3:0]  blk;
      logic [4:0]  word;
      logic [1:0]  grp;
      logic [31:0] data;
      logic [9:0]  irq;
      logic        level;
   } item_type;

   typedef enum logic [2:0] {
      BK_IDLE, BK_EXEC, BK_RDWAIT, BK_STAT, BK_PEND, BK_GRPWAIT, BK_DONE
   } bk_state_type;

   // index of the lowest set bit (0 when none)
   function automatic logic [4:0] lowest_bit(input logic [31:0] v);
      logic [4:0] idx;
      idx = '0;
      for (int i = 31; i >= 0; i--) begin
         if (v[i]) idx = 5'(i);
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

// ===== design/vic_if.sv =====
// vic_req_if / vic_rsp_if: valid-ready channels for request and response
// transactions. Depends on nothing.
`default_nettype none

interface vic_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  command;
   logic [3:0]  reg_block;
   logic [4:0]  word_index;
   logic [31:0] write_data;
   logic [9:0]  irq_number;
   logic        line_level;
   modport source (output valid, command, reg_block, word_index, write_data,
                   irq_number, line_level, input ready);
   modport sink   (input valid, command, reg_block, word_index, write_data,
                   irq_number, line_level, output ready);
endinterface

interface vic_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] read_data;
   logic        pulse_valid;
   logic [2:0]  pulse_line;
   logic [9:0]  delivered_irq;
   logic        access_error;
   modport source (output valid, read_data, pulse_valid, pulse_line,
                   delivered_irq, access_error, input ready);
   modport sink   (input valid, read_data, pulse_valid, pulse_line,
                   delivered_irq, access_error, output ready);
endinterface

`default_nettype wire

// ===== design/vic_front.sv =====
// vic_front: accepts request transactions, decodes them into operations
// and queues them for the back end. Depends on vic_pkg and vic_req_if.
`default_nettype none

module vic_front
   import vic_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   vic_req_if.sink   req,
   output item_type  q_item,
   output logic      q_valid,
   input  wire logic q_pop
);

   item_type   dec;
   logic       word_ok;
   logic       push;
   item_type   buf_ff [QUEUE_DEPTH];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;

   // classify the transaction
   always_comb begin
      word_ok   = {1'b0, req.word_index} < 6'(NUM_WORDS);
      dec.blk   = req.reg_block;
      dec.word  = req.word_index;
      dec.grp   = 2'(req.reg_block - BLK_GRP0);
      dec.data  = req.write_data;
      dec.irq   = req.irq_number;
      dec.level = req.line_level;
      dec.op    = OP_NOP;
      case (req.command)
         CMD_WRITE: begin
            if (req.reg_block == BLK_VID0) begin
               dec.op = (req.word_index == 5'd0) ? OP_VID0_WR : OP_BAD;
            end else if (req.reg_block == BLK_VGRP || req.reg_block > BLK_GRP3
                         || !word_ok) begin
               dec.op = OP_BAD;
            end else begin
               case (req.reg_block) inside
                  BLK_ENABLE:  dec.op = OP_EN_WR;
                  BLK_EN_CLR:  dec.op = OP_EN_CLR;
                  BLK_EN_SET:  dec.op = OP_EN_SET;
                  BLK_TYPE:    dec.op = OP_TYPE_WR;
                  BLK_STATUS:  dec.op = OP_STAT_WR;
                  BLK_CLEAR:   dec.op = OP_CLR_WR;
                  BLK_SOFT:    dec.op = OP_SOFT_WR;
                  BLK_PENDING: dec.op = OP_PEND_WR;
                  default:     dec.op = OP_GRP_WR;
               endcase
            end
         end
         CMD_READ: begin
            if (req.reg_block == BLK_VID0) begin
               dec.op = (req.word_index == 5'd0) ? OP_RD_REG : OP_BAD;
            end else if (req.reg_block == BLK_VGRP) begin
               dec.op = (req.word_index < 5'd4) ? OP_RD_REG : OP_BAD;
            end else if (req.reg_block > BLK_GRP3 || !word_ok) begin
               dec.op = OP_BAD;
            end else begin
               case (req.reg_block) inside
                  BLK_EN_CLR, BLK_EN_SET, BLK_SOFT: dec.op = OP_RD_ZERO;
                  BLK_GRP0, BLK_GRP1, BLK_GRP2, BLK_GRP3: dec.op = OP_RD_GRP;
                  default: dec.op = OP_RD_REG;
               endcase
            end
         end
         CMD_LINE:  dec.op = OP_LINE;
         CMD_FAST:  dec.op = OP_FAST;
         CMD_RESET: dec.op = OP_RESET;
         default:   dec.op = OP_NOP;
      endcase
   end

   // two-entry queue toward the back end
   assign req.ready = (cnt_ff != 2'(QUEUE_DEPTH));
   assign push      = req.valid && req.ready;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_item    = buf_ff[rp_ff];

   always_comb begin
      wp_in  = push  ? ~wp_ff : wp_ff;
      rp_in  = q_pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) buf_ff[wp_ff] <= dec;
   end

endmodule

`default_nettype wire

// ===== design/vic_back.sv =====
// vic_back: executes queued operations on the source state, scans for a
// deliverable source and holds the response. Depends on vic_pkg, vic_rsp_if.
`default_nettype none

module vic_back
   import vic_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data,
   input  item_type         q_item,
   input  wire logic        q_valid,
   output logic             q_pop,
   vic_rsp_if.source        rsp
);

   bk_state_type st_ff, st_in;
   item_type     item_ff;
   logic [4:0]   scan_ff;

   logic [31:0] en_ff [WORDS_MAX];
   logic [31:0] pd_ff [WORDS_MAX];
   logic [31:0] ss_ff [WORDS_MAX];
   logic [31:0] ty_ff [WORDS_MAX];
   logic [31:0] cw_ff [WORDS_MAX];
   logic [31:0] cur_ff;
   logic [9:0]  gv_ff [4];
   logic [31:0] cc_ff;

   logic [31:0] gmem [GRP_DEPTH];
   logic        gval_ff [GRP_DEPTH];
   logic [31:0] grd_ff;
   logic        grdv_ff;
   logic [GRP_AW-1:0] raddr;
   logic        gm_we;

   logic [4:0]  hit_w_ff, hit_b_ff;
   logic [31:0] cand;
   logic [4:0]  cand_b;
   logic [9:0]  cand_irq, hit_irq;

   logic [31:0] r_rd_ff;
   logic        r_err_ff, r_pv_ff;
   logic [2:0]  r_line_ff;
   logic [9:0]  r_irq_ff;
   logic        rv_ff;
   logic [31:0] rd_ff;
   logic        err_ff, pv_ff;
   logic [2:0]  line_ff;
   logic [9:0]  irq_ff;
   logic        rsp_load;

   logic [31:0] ex_rd;
   logic        ex_err;
   logic [9:0]  src;
   logic [1:0]  fc;
   logic [31:0] src_bit;
   logic        fast_bad;
   logic [3:0]  nib;
   logic [1:0]  vid;
   logic        last_stat, last_pend;

   // scan helpers
   always_comb begin
      cand      = pd_ff[scan_ff] & en_ff[scan_ff];
      cand_b    = lowest_bit(cand);
      cand_irq  = {scan_ff, cand_b};
      hit_irq   = {hit_w_ff, hit_b_ff};
      last_stat = (scan_ff == 5'(WORDS_MAX - 1));
      last_pend = (scan_ff == 5'(NUM_WORDS - 1));
      nib       = grdv_ff ? grd_ff[{hit_b_ff[2:0], 2'b00} +: 4] : 4'd0;
      vid       = nib[3] ? nib[1:0] : 2'd0;
   end

   // fast command decode
   always_comb begin
      src      = item_ff.data[9:0];
      fc       = item_ff.data[17:16];
      src_bit  = 32'd1 << src[4:0];
      fast_bad = (item_ff.word != 5'd0) || ({1'b0, src} >= 11'(NUM_SOURCES))
                 || (fc == FC_BAD);
   end

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         BK_IDLE:    if (q_valid) st_in = BK_EXEC;
         BK_EXEC:    st_in = (item_ff.op == OP_RD_GRP) ? BK_RDWAIT : BK_STAT;
         BK_RDWAIT:  st_in = BK_STAT;
         BK_STAT: begin
            if (ss_ff[scan_ff] != 32'd0) st_in = BK_DONE;
            else if (last_stat)          st_in = BK_PEND;
         end
         BK_PEND: begin
            if (cand != 32'd0) begin
               st_in = ({1'b0, cand_irq} >= 11'(NUM_SOURCES)) ? BK_DONE : BK_GRPWAIT;
            end else if (last_pend) begin
               st_in = BK_DONE;
            end
         end
         BK_GRPWAIT: st_in = BK_DONE;
         BK_DONE:    if (rsp_load) st_in = BK_IDLE;
         default:    st_in = BK_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      q_pop    = (st_ff == BK_IDLE) && q_valid;
      rsp_load = (st_ff == BK_DONE) && (!rv_ff || rsp.ready);
      gm_we    = (st_ff == BK_EXEC) && (item_ff.op == OP_GRP_WR);
      raddr    = (st_ff == BK_PEND) ? {cand_b[4:3], scan_ff}
                                    : {item_ff.grp, item_ff.word};
   end

   // read data and error of the executed operation
   always_comb begin
      ex_err = 1'b0;
      ex_rd  = 32'd0;
      case (item_ff.op)
         OP_BAD:     ex_err = 1'b1;
         OP_SOFT_WR: ex_err = (item_ff.data == 32'd0);
         OP_FAST:    ex_err = fast_bad;
         OP_RD_REG: begin
            case (item_ff.blk)
               BLK_VID0:    ex_rd = cur_ff;
               BLK_VGRP:    ex_rd = {22'd0, gv_ff[item_ff.word[1:0]]};
               BLK_ENABLE:  ex_rd = en_ff[item_ff.word];
               BLK_TYPE:    ex_rd = ty_ff[item_ff.word];
               BLK_STATUS:  ex_rd = ss_ff[item_ff.word];
               BLK_CLEAR:   ex_rd = cw_ff[item_ff.word];
               BLK_PENDING: ex_rd = pd_ff[item_ff.word];
               default:     ex_rd = 32'd0;
            endcase
         end
         default: ;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= BK_IDLE;
         scan_ff <= 5'd0;
         rv_ff   <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (st_ff == BK_EXEC || st_ff == BK_RDWAIT) scan_ff <= 5'd0;
         else if (st_ff == BK_STAT) scan_ff <= last_stat ? 5'd0 : scan_ff + 5'd1;
         else if (st_ff == BK_PEND) scan_ff <= scan_ff + 5'd1;
         if (rsp_load)                rv_ff <= 1'b1;
         else if (rsp.ready)          rv_ff <= 1'b0;
      end
   end

   // source state, vectors and completion code
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WORDS_MAX; i++) begin
            en_ff[i] <= '0; pd_ff[i] <= '0; ss_ff[i] <= '0;
            ty_ff[i] <= '0; cw_ff[i] <= '0;
         end
         for (int i = 0; i < 4; i++) gv_ff[i] <= '0;
         cur_ff <= '0;
         cc_ff  <= '0;
      end else begin
         if (csr_wr_en) cc_ff <= csr_wr_data;
         if (st_ff == BK_EXEC) begin
            case (item_ff.op)
               OP_VID0_WR: begin
                  if (item_ff.data != cc_ff) cur_ff <= item_ff.data;
                  else if (cur_ff < 32'(NUM_SOURCES))
                     ss_ff[cur_ff[9:5]][cur_ff[4:0]] <= 1'b0;
               end
               OP_EN_WR:   en_ff[item_ff.word] <= item_ff.data;
               OP_EN_CLR:  en_ff[item_ff.word] <= en_ff[item_ff.word] & ~item_ff.data;
               OP_EN_SET:  en_ff[item_ff.word] <= en_ff[item_ff.word] | item_ff.data;
               OP_TYPE_WR: ty_ff[item_ff.word] <= item_ff.data;
               OP_STAT_WR: ss_ff[item_ff.word] <= item_ff.data;
               OP_CLR_WR:  cw_ff[item_ff.word] <= item_ff.data;
               OP_PEND_WR: pd_ff[item_ff.word] <= item_ff.data;
               OP_SOFT_WR: begin
                  // lowest set bit pends only when its source is edge type
                  en_ff[item_ff.word] <= en_ff[item_ff.word] | item_ff.data;
                  pd_ff[item_ff.word] <= pd_ff[item_ff.word]
                     | (item_ff.data & (~item_ff.data + 32'd1) & ty_ff[item_ff.word]);
               end
               OP_LINE: begin
                  if ({1'b0, item_ff.irq} < 11'(NUM_SOURCES) && item_ff.level)
                     pd_ff[item_ff.irq[9:5]][item_ff.irq[4:0]] <= 1'b1;
               end
               OP_FAST: begin
                  if (!fast_bad) begin
                     case (fc)
                        FC_ENABLE:  en_ff[src[9:5]] <= en_ff[src[9:5]] | src_bit;
                        FC_DISABLE: en_ff[src[9:5]] <= en_ff[src[9:5]] & ~src_bit;
                        default: begin
                           en_ff[src[9:5]] <= en_ff[src[9:5]] | src_bit;
                           pd_ff[src[9:5]] <= pd_ff[src[9:5]] | (src_bit & ty_ff[src[9:5]]);
                        end
                     endcase
                  end
               end
               OP_RESET: begin
                  for (int i = 0; i < WORDS_MAX; i++) begin
                     en_ff[i] <= '0; pd_ff[i] <= '0; ss_ff[i] <= '0;
                     ty_ff[i] <= '0; cw_ff[i] <= '0;
                  end
                  cur_ff <= '0;
               end
               default: ;
            endcase
         end
         // delivery of the found source
         if (st_ff == BK_GRPWAIT) begin
            ss_ff[hit_w_ff][hit_b_ff] <= 1'b1;
            pd_ff[hit_w_ff][hit_b_ff] <= 1'b0;
            en_ff[hit_w_ff][hit_b_ff] <= 1'b0;
            cur_ff    <= {22'd0, hit_irq};
            gv_ff[vid] <= hit_irq;
         end
      end
   end

   // group table valid bits
   always_ff @(posedge clock) begin
      if (reset || (st_ff == BK_EXEC && item_ff.op == OP_RESET)) begin
         for (int i = 0; i < GRP_DEPTH; i++) gval_ff[i] <= 1'b0;
      end else if (gm_we) begin
         gval_ff[{item_ff.grp, item_ff.word}] <= 1'b1;
      end
   end

   // group table memory
   always_ff @(posedge clock) begin
      if (gm_we) gmem[{item_ff.grp, item_ff.word}] <= item_ff.data;
      grd_ff  <= gmem[raddr];
      grdv_ff <= gval_ff[raddr];
   end

   // transaction payload and result
   always_ff @(posedge clock) begin
      if (q_pop) item_ff <= q_item;
      if (st_ff == BK_EXEC) begin
         r_rd_ff   <= ex_rd;
         r_err_ff  <= ex_err;
         r_pv_ff   <= 1'b0;
         r_line_ff <= 3'd0;
         r_irq_ff  <= 10'd0;
      end
      if (st_ff == BK_RDWAIT) r_rd_ff <= grdv_ff ? grd_ff : 32'd0;
      if (st_ff == BK_PEND && cand != 32'd0) begin
         hit_w_ff <= scan_ff;
         hit_b_ff <= cand_b;
      end
      if (st_ff == BK_GRPWAIT) begin
         r_pv_ff   <= 1'b1;
         r_line_ff <= 3'(vid) + 3'd2;
         r_irq_ff  <= hit_irq;
      end
      if (rsp_load) begin
         rd_ff   <= r_rd_ff;
         err_ff  <= r_err_ff;
         pv_ff   <= r_pv_ff;
         line_ff <= r_line_ff;
         irq_ff  <= r_irq_ff;
      end
   end

   assign rsp.valid         = rv_ff;
   assign rsp.read_data     = rd_ff;
   assign rsp.pulse_valid   = pv_ff;
   assign rsp.pulse_line    = line_ff;
   assign rsp.delivered_irq = irq_ff;
   assign rsp.access_error  = err_ff;

endmodule

`default_nettype wire

// ===== design/vectored_interrupt_controller.sv =====
// vectored_interrupt_controller: top level joining the decode front end
// and the execute back end. Depends on vic_pkg, vic_if, vic_front, vic_back.
//
//   channel  dir  handshake            payload
//   req      in   valid / ready        command, reg_block, word_index,
//                                      write_data, irq_number, line_level
//   rsp      out  valid / ready        read_data, pulse_valid, pulse_line,
//                                      delivered_irq, access_error
//   csr      in   csr_wr_en            csr_wr_data (completion code)
//
// one transaction passes through these steps: taking it from the queue,
// execute, a group table read for a group register read, a status word scan
// that stops at the first nonzero word (up to 32 words), if none is found a
// scan of the pending-and-enable words (up to 32), a group table read on a
// delivery and a response load. the back end handles one transaction at a time;
// a two-entry queue keeps accepting requests, the response register holds a
// stalled result, and synchronous reset clears control, source state and group valid bits at once.
`default_nettype none

module vectored_interrupt_controller
   import vic_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data,
   vic_req_if.sink          req,
   vic_rsp_if.source        rsp
);

   item_type q_item;
   logic     q_valid;
   logic     q_pop;

   vic_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .q_item  (q_item),
      .q_valid (q_valid),
      .q_pop   (q_pop)
   );

   vic_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_item      (q_item),
      .q_valid     (q_valid),
      .q_pop       (q_pop),
      .rsp         (rsp)
   );

endmodule

`default_nettype wire

// ===== design/vic_checker.sv =====
// vic_checker: port-level checks on the response channel, bound to the
// top level. Depends on vectored_interrupt_controller.
`default_nettype none

module vic_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_pulse_valid,
   input wire logic [2:0] rsp_pulse_line,
   input wire logic [9:0] rsp_delivered_irq
);

   // a stalled response stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // no response right after reset
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

   // no delivery means zero line and source
   a_no_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_pulse_valid |-> rsp_pulse_line == 3'd0
                                        && rsp_delivered_irq == 10'd0)
      else $error("pulse fields set without delivery");

   // a delivered line is vid plus two, so it lies between 2 and 5
   a_pulse_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pulse_valid |-> rsp_pulse_line >= 3'd2
                                       && rsp_pulse_line <= 3'd5)
      else $error("pulse line out of range");

endmodule

bind vectored_interrupt_controller vic_checker u_vic_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_pulse_valid   (rsp.pulse_valid),
   .rsp_pulse_line    (rsp.pulse_line),
   .rsp_delivered_irq (rsp.delivered_irq)
);

`default_nettype wire
